// ===== hw/rtl/bpfc_pkg.sv =====
// Package for the buffer pool frame cache: action and status codes, request and result types.
// No dependencies.
package bpfc_pkg;
    typedef enum logic [1:0] {
        ACT_ACCESS  = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_DIRTY   = 2'd2,
        ACT_FLUSH   = 2'd3
    } t_action;

    localparam logic [2:0] ST_HIT  = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_OOB  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_index;
        logic        writeback;
        logic [31:0] writeback_page;
        logic        load_needed;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] page_number;
        logic [3:0]  frame_select;
        logic [31:0] file_pages;
    } t_request;
endpackage

// ===== hw/rtl/bpfc_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on bpfc_pkg.
interface bpfc_req_if import bpfc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_request data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpfc_res_if import bpfc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/buffer_pool_frame_cache_unit.sv =====
// Top level of the buffer pool frame cache: controller plus directory datapath.
// Depends on bpfc_pkg, bpfc_if, bpfc_ctrl and bpfc_datapath.
//
//   channel   dir   contents
//   req       in    action, page_number, frame_select, file_pages
//   res       out   status, frame_index, writeback, writeback_page, load_needed, last
//
// A hit scans the directory frame by frame, each frame read from the page RAM and then
// compared; a miss adds a victim search over up to FRAMES frames in replacement order.
// Flush visits frames up to the last dirty one (all frames when none is dirty) and
// can stall on each result. A new item waits until the previous result is taken.
// Reset is synchronous; the page store needs no clearing pass.
module buffer_pool_frame_cache_unit import bpfc_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpfc_req_if.sink   req,
    bpfc_res_if.source res
);
    localparam int IW = $clog2(FRAMES);

    logic [IW-1:0]        w_scan, w_ord_frame, w_sel, w_raddr;
    logic                 w_scan_end, w_cur_valid, w_cur_dirty, w_ord_free;
    logic                 w_ord_wb, w_more;
    logic                 w_clr, w_inc, w_hit, w_miss, w_rel, w_dirty, w_clean;
    logic [PAGE_BITS-1:0] w_rdata, w_page;

    bpfc_ctrl #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .res(res),
        .i_scan(w_scan), .i_scan_end(w_scan_end), .i_cur_valid(w_cur_valid),
        .i_cur_dirty(w_cur_dirty), .i_ord_free(w_ord_free), .i_ord_wb(w_ord_wb),
        .i_more(w_more), .i_ord_frame(w_ord_frame), .i_rdata(w_rdata), .o_page(w_page),
        .o_sel(w_sel), .o_scan_clr(w_clr), .o_scan_inc(w_inc), .o_op_hit(w_hit),
        .o_op_miss(w_miss), .o_op_rel(w_rel), .o_op_dirty(w_dirty),
        .o_op_clean(w_clean), .o_raddr(w_raddr)
    );

    bpfc_datapath #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sel(w_sel),
        .i_page(w_page), .i_scan_clr(w_clr), .i_scan_inc(w_inc),
        .i_op_hit(w_hit), .i_op_miss(w_miss), .i_op_rel(w_rel),
        .i_op_dirty(w_dirty), .i_op_clean(w_clean), .i_raddr(w_raddr),
        .o_scan(w_scan), .o_scan_end(w_scan_end), .o_cur_valid(w_cur_valid),
        .o_cur_dirty(w_cur_dirty), .o_ord_free(w_ord_free), .o_ord_wb(w_ord_wb),
        .o_more(w_more), .o_ord_frame(w_ord_frame), .o_rdata(w_rdata)
    );

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_hit, w_miss, w_rel, w_dirty, w_clean}))
        else $error("several directory updates in one cycle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_miss |-> !req.ready)
        else $error("request taken during a remap");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result dropped while stalled");
endmodule

// ===== hw/rtl/bpfc_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module bpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/bpfc_datapath.sv =====
// Frame directory datapath: per-frame flags, pin counts, replacement order,
// page RAM and the scan pointer. Depends on bpfc_pkg and bpfc_ram.
module bpfc_datapath import bpfc_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [$clog2(FRAMES)-1:0] i_sel,
    input  logic [PAGE_BITS-1:0]      i_page,
    input  logic                      i_scan_clr,
    input  logic                      i_scan_inc,
    input  logic                      i_op_hit,
    input  logic                      i_op_miss,
    input  logic                      i_op_rel,
    input  logic                      i_op_dirty,
    input  logic                      i_op_clean,
    input  logic [$clog2(FRAMES)-1:0] i_raddr,
    output logic [$clog2(FRAMES)-1:0] o_scan,
    output logic                      o_scan_end,
    output logic                      o_cur_valid,
    output logic                      o_cur_dirty,
    output logic                      o_ord_free,
    output logic                      o_ord_wb,
    output logic                      o_more,
    output logic [$clog2(FRAMES)-1:0] o_ord_frame,
    output logic [PAGE_BITS-1:0]      o_rdata
);
    localparam int IW = $clog2(FRAMES);
    localparam logic [IW-1:0] LASTI = IW'(FRAMES - 1);

    logic [IW-1:0]     r_scan;
    logic              r_valid [FRAMES];
    logic              r_dirty [FRAMES];
    logic              r_refd  [FRAMES];
    logic [7:0]        r_pins  [FRAMES];
    logic [IW-1:0]     r_order [FRAMES];
    logic [IW-1:0]     w_f;
    logic [FRAMES-1:0] w_after;

    assign o_scan      = r_scan;
    assign o_scan_end  = (r_scan == LASTI);
    assign o_cur_valid = r_valid[r_scan];
    assign o_cur_dirty = r_dirty[r_scan];
    assign w_f         = r_order[r_scan];
    assign o_ord_frame = w_f;
    assign o_ord_free  = (r_pins[w_f] == 8'd0);
    assign o_ord_wb    = r_valid[w_f] && r_dirty[w_f];
    assign o_more      = |w_after;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            w_after[i] = r_valid[i] && r_dirty[i] && (IW'(i) > r_scan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_refd[i]  <= 1'b0;
                r_pins[i]  <= 8'd0;
                r_order[i] <= IW'(FRAMES - 1 - i);
            end
        end else begin
            if (i_scan_clr) begin
                r_scan <= '0;
            end else if (i_scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_op_hit) begin
                r_refd[r_scan] <= 1'b1;
                if (r_pins[r_scan] != 8'hFF) begin
                    r_pins[r_scan] <= r_pins[r_scan] + 8'd1;
                end
            end
            if (i_op_miss) begin
                r_valid[w_f] <= 1'b1;
                r_dirty[w_f] <= 1'b0;
                r_refd[w_f]  <= 1'b0;
                r_pins[w_f]  <= 8'd1;
                for (int i = 0; i < FRAMES - 1; i++) begin
                    if (IW'(i) >= r_scan) begin
                        r_order[i] <= r_order[i + 1];
                    end
                end
                r_order[FRAMES - 1] <= w_f;
            end
            if (i_op_rel && r_pins[i_sel] != 8'd0) begin
                r_pins[i_sel] <= r_pins[i_sel] - 8'd1;
            end
            if (i_op_dirty && r_valid[i_sel]) begin
                r_dirty[i_sel] <= 1'b1;
            end
            if (i_op_clean) begin
                r_dirty[r_scan] <= 1'b0;
            end
        end
    end

    bpfc_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_pages (
        .i_clk   (i_clk),
        .i_we    (i_op_miss),
        .i_waddr (w_f),
        .i_wdata (i_page),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );
endmodule

// ===== hw/rtl/bpfc_ctrl.sv =====
// Sequencer for the frame directory: lookup scan, victim search, flush scan,
// release and dirty updates and result handoff. Depends on bpfc_pkg and drives bpfc_datapath.
module bpfc_ctrl import bpfc_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bpfc_req_if.sink                  req,
    bpfc_res_if.source                res,
    input  logic [$clog2(FRAMES)-1:0] i_scan,
    input  logic                      i_scan_end,
    input  logic                      i_cur_valid,
    input  logic                      i_cur_dirty,
    input  logic                      i_ord_free,
    input  logic                      i_ord_wb,
    input  logic                      i_more,
    input  logic [$clog2(FRAMES)-1:0] i_ord_frame,
    input  logic [PAGE_BITS-1:0]      i_rdata,
    output logic [PAGE_BITS-1:0]      o_page,
    output logic [$clog2(FRAMES)-1:0] o_sel,
    output logic                      o_scan_clr,
    output logic                      o_scan_inc,
    output logic                      o_op_hit,
    output logic                      o_op_miss,
    output logic                      o_op_rel,
    output logic                      o_op_dirty,
    output logic                      o_op_clean,
    output logic [$clog2(FRAMES)-1:0] o_raddr
);
    localparam int IW = $clog2(FRAMES);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_LCMP, S_VICT, S_VRD, S_VOUT, S_FLSH, S_FRD, S_FOUT, S_OUT
    } t_state;

    t_state         r_state;
    t_request       r_req;
    t_result        r_res;
    logic           r_rvalid;
    logic           r_any;
    logic [IW-1:0]  r_frame;
    logic           r_wb;
    logic [PAGE_BITS-1:0] w_page;
    logic           w_sel_ok;

    assign w_page   = PAGE_BITS'(r_req.page_number);
    assign o_page   = w_page;
    assign o_sel    = IW'(r_req.frame_select);
    assign w_sel_ok = ({28'd0, r_req.frame_select} < 32'(FRAMES));
    assign req.ready = (r_state == S_IDLE) && !r_rvalid;
    assign res.valid = r_rvalid;
    assign res.data  = r_res;

    always_comb begin
        o_scan_clr = 1'b0;
        o_scan_inc = 1'b0;
        o_op_hit   = 1'b0;
        o_op_miss  = 1'b0;
        o_op_rel   = 1'b0;
        o_op_dirty = 1'b0;
        o_op_clean = 1'b0;
        o_raddr    = i_scan;
        unique case (r_state)
            S_IDLE: o_scan_clr = 1'b1;
            S_LCMP: begin
                if (i_cur_valid && i_rdata == w_page) begin
                    o_op_hit = 1'b1;
                end else if (i_scan_end) begin
                    o_scan_clr = 1'b1;
                end else begin
                    o_scan_inc = 1'b1;
                end
            end
            S_VICT: begin
                o_raddr = i_ord_frame;
                if (i_ord_free) begin
                    o_op_miss = 1'b0;
                end else if (!i_scan_end) begin
                    o_scan_inc = 1'b1;
                end
            end
            S_VRD: begin
                o_raddr   = i_ord_frame;
                o_op_miss = 1'b1;
            end
            S_OUT: begin
                o_op_rel   = (r_req.action == ACT_RELEASE) && w_sel_ok;
                o_op_dirty = (r_req.action == ACT_DIRTY) && w_sel_ok;
            end
            S_FRD: o_op_clean = 1'b1;
            S_FOUT: begin
                if ((!r_rvalid || res.ready) && i_more) begin
                    o_scan_inc = 1'b1;
                end
            end
            S_FLSH: begin
                if (!(i_cur_valid && i_cur_dirty) && !i_scan_end) begin
                    o_scan_inc = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            if (r_rvalid && res.ready) begin
                r_rvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        r_req <= req.data;
                        r_any <= 1'b0;
                        unique case (t_action'(req.data.action))
                            ACT_ACCESS: begin
                                if (req.data.page_number >= req.data.file_pages) begin
                                    r_res    <= '{ST_OOB, 4'd0, 1'b0, 32'd0, 1'b0, 1'b1};
                                    r_rvalid <= 1'b1;
                                end else begin
                                    r_state <= S_LOOK;
                                end
                            end
                            ACT_FLUSH: r_state <= S_FLSH;
                            default:   r_state <= S_OUT;
                        endcase
                    end
                end
                S_LOOK: r_state <= S_LCMP;
                S_LCMP: begin
                    if (i_cur_valid && i_rdata == w_page) begin
                        r_res    <= '{ST_HIT, 4'(i_scan), 1'b0, 32'd0, 1'b0, 1'b1};
                        r_rvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (i_scan_end) begin
                        r_state <= S_VICT;
                    end else begin
                        r_state <= S_LOOK;
                    end
                end
                S_VICT: begin
                    if (i_ord_free) begin
                        r_frame <= i_ord_frame;
                        r_wb    <= i_ord_wb;
                        r_state <= S_VRD;
                    end else if (i_scan_end) begin
                        r_res    <= '{ST_FULL, 4'd0, 1'b0, 32'd0, 1'b0, 1'b1};
                        r_rvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_VRD: begin
                    r_state <= S_VOUT;
                end
                S_VOUT: begin
                    r_res    <= '{ST_MISS, 4'(r_frame), r_wb,
                                  r_wb ? 32'(i_rdata) : 32'd0, 1'b1, 1'b1};
                    r_rvalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_OUT: begin
                    r_res    <= '{ST_DONE, r_req.frame_select, 1'b0, 32'd0, 1'b0, 1'b1};
                    r_rvalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_FLSH: begin
                    if (i_cur_valid && i_cur_dirty) begin
                        r_state <= S_FRD;
                    end else if (i_scan_end) begin
                        if (!r_any) begin
                            r_res    <= '{ST_DONE, 4'd0, 1'b0, 32'd0, 1'b0, 1'b1};
                            r_rvalid <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FRD: r_state <= S_FOUT;
                S_FOUT: begin
                    if (!r_rvalid || res.ready) begin
                        r_res    <= '{ST_DONE, 4'(i_scan), 1'b1, 32'(i_rdata), 1'b0,
                                      !i_more};
                        r_rvalid <= 1'b1;
                        r_any    <= 1'b1;
                        r_state  <= i_more ? S_FLSH : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the buffer pool frame cache: a directory predictor in a scoreboard
// class checks every result. Depends on bpfc_pkg, bpfc_if and buffer_pool_frame_cache_unit.
module testbench;
    import bpfc_pkg::*;

    localparam int NFRAMES = 16;
    localparam int LIMIT = 400000;

    class frame_directory;
        logic [31:0] page_of [NFRAMES];
        bit          valid_of [NFRAMES];
        bit          dirty_of [NFRAMES];
        int unsigned pins_of [NFRAMES];
        bit          refd_of [NFRAMES];
        int unsigned age_order [NFRAMES];
        t_result     pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < NFRAMES; i++) begin
                page_of[i] = '0;
                valid_of[i] = 0;
                dirty_of[i] = 0;
                pins_of[i] = 0;
                refd_of[i] = 0;
                age_order[i] = NFRAMES - 1 - i;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [2:0] st, int fi, bit wb, logic [31:0] wp, bit ld, bit lst);
            t_result r;
            r.status = st;
            r.frame_index = fi[3:0];
            r.writeback = wb;
            r.writeback_page = wp;
            r.load_needed = ld;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_request(t_request q);
            int p;
            int f;
            int n;
            bit wb;
            logic [31:0] wp;
            n = 0;
            case (t_action'(q.action))
                ACT_ACCESS: begin
                    if (q.page_number >= q.file_pages) begin
                        push(ST_OOB, 0, 0, '0, 0, 1);
                        return;
                    end
                    for (int i = 0; i < NFRAMES; i++) begin
                        if (valid_of[i] && page_of[i] == q.page_number) begin
                            refd_of[i] = 1;
                            if (pins_of[i] < 255) pins_of[i]++;
                            push(ST_HIT, i, 0, '0, 0, 1);
                            return;
                        end
                    end
                    for (p = 0; p < NFRAMES; p++) begin
                        if (pins_of[age_order[p]] == 0) break;
                    end
                    if (p >= NFRAMES) begin
                        push(ST_FULL, 0, 0, '0, 0, 1);
                        return;
                    end
                    f = age_order[p];
                    wb = valid_of[f] && dirty_of[f];
                    wp = wb ? page_of[f] : '0;
                    dirty_of[f] = 0;
                    page_of[f] = q.page_number;
                    valid_of[f] = 1;
                    refd_of[f] = 0;
                    pins_of[f] = 1;
                    for (int i = p; i + 1 < NFRAMES; i++) age_order[i] = age_order[i + 1];
                    age_order[NFRAMES - 1] = f;
                    push(ST_MISS, f, wb, wp, 1, 1);
                end
                ACT_RELEASE: begin
                    if (pins_of[q.frame_select] > 0) pins_of[q.frame_select]--;
                    push(ST_DONE, q.frame_select, 0, '0, 0, 1);
                end
                ACT_DIRTY: begin
                    if (valid_of[q.frame_select]) dirty_of[q.frame_select] = 1;
                    push(ST_DONE, q.frame_select, 0, '0, 0, 1);
                end
                default: begin
                    for (int i = 0; i < NFRAMES; i++) begin
                        if (valid_of[i] && dirty_of[i]) begin
                            dirty_of[i] = 0;
                            push(ST_DONE, i, 1, page_of[i], 0, 0);
                            n++;
                        end
                    end
                    if (n == 0) push(ST_DONE, 0, 0, '0, 0, 1);
                    else pending[$].last = 1;
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.frame_index !== exp.frame_index) begin
                $error("frame_index: expected %0d, actual %0d", exp.frame_index,
                       got.frame_index);
                errors++;
            end
            if (got.writeback !== exp.writeback) begin
                $error("writeback: expected %0d, actual %0d", exp.writeback, got.writeback);
                errors++;
            end
            if (got.writeback_page !== exp.writeback_page) begin
                $error("writeback_page: expected %0h, actual %0h", exp.writeback_page,
                       got.writeback_page);
                errors++;
            end
            if (got.load_needed !== exp.load_needed) begin
                $error("load_needed: expected %0d, actual %0d", exp.load_needed,
                       got.load_needed);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    bit   stall_mode;
    logic [31:0] page_pool [8];
    frame_directory board;

    bpfc_req_if req ();
    bpfc_res_if res ();

    buffer_pool_frame_cache_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req.sink),
        .res     (res.source)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) board.check_result(res.data);
        if (!i_rst_n) begin
            res.ready <= 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
            res.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
        end
    end

    task automatic send_item(t_request q);
        req.data <= q;
        req.valid <= 1;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        board.note_request(q);
    endtask

    function automatic t_request make_item(t_action a, logic [31:0] pg, logic [3:0] fs,
                                           logic [31:0] bound);
        t_request q;
        q.action = a;
        q.page_number = pg;
        q.frame_select = fs;
        q.file_pages = bound;
        return q;
    endfunction

    task automatic idle_cycles(int n);
        req.valid <= 0;
        req.data <= make_item(t_action'(2'($urandom_range(0, 3))), $urandom,
                              4'($urandom), $urandom);
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_request random_item();
        int k;
        logic [31:0] pg;
        k = $urandom_range(0, 99);
        pg = ($urandom_range(0, 3) == 0) ? $urandom : page_pool[$urandom_range(0, 7)];
        if (k < 50) begin
            return make_item(ACT_ACCESS, pg, 4'($urandom),
                             ($urandom_range(0, 9) == 0) ? $urandom : 32'hFFFF_FFFF);
        end else if (k < 75) begin
            return make_item(ACT_RELEASE, $urandom, 4'($urandom), $urandom);
        end else if (k < 92) begin
            return make_item(ACT_DIRTY, $urandom, 4'($urandom), $urandom);
        end
        return make_item(ACT_FLUSH, $urandom, 4'($urandom), $urandom);
    endfunction

    initial begin
        int burst;
        board = new();
        board.clear();
        cycles = 0;
        stall_mode = 0;
        i_rst_n = 0;
        req.valid = 0;
        req.data = '0;
        res.ready = 0;
        for (int i = 0; i < 8; i++) page_pool[i] = $urandom;
        page_pool[0] = 32'h0;
        page_pool[1] = 32'hFFFF_FFFE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_item(make_item(ACT_FLUSH, 32'd0, 4'd0, 32'd0));
        send_item(make_item(ACT_DIRTY, 32'd0, 4'd3, 32'd0));
        send_item(make_item(ACT_RELEASE, 32'd0, 4'd3, 32'd0));
        send_item(make_item(ACT_ACCESS, 32'd5, 4'd0, 32'd5));
        send_item(make_item(ACT_ACCESS, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF));
        send_item(make_item(ACT_ACCESS, 32'hFFFF_FFFE, 4'hF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_ACCESS, 32'h0, 4'd0, 32'h1));
        send_item(make_item(ACT_ACCESS, 32'h0, 4'd0, 32'h1));
        for (int i = 0; i < 16; i++) send_item(make_item(ACT_DIRTY, 32'd0, 4'(i), 32'd0));
        send_item(make_item(ACT_FLUSH, 32'd0, 4'd0, 32'd0));
        for (int i = 2; i < 16; i++) begin
            send_item(make_item(ACT_ACCESS, 32'h100 + 32'(i), 4'd0, '1));
        end
        send_item(make_item(ACT_ACCESS, 32'h2000, 4'd0, '1));
        for (int i = 0; i < 16; i++) send_item(make_item(ACT_RELEASE, 32'd0, 4'(i), 32'd0));
        send_item(make_item(ACT_ACCESS, 32'h2001, 4'd0, '1));
        for (int i = 0; i < 16; i++) send_item(make_item(ACT_DIRTY, 32'd0, 4'(i), 32'd0));
        send_item(make_item(ACT_FLUSH, 32'd0, 4'd0, 32'd0));
        for (int i = 0; i < 16; i++) send_item(make_item(ACT_RELEASE, 32'd0, 4'(i), 32'd0));

        for (int n = 0; n < 140; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                send_item(random_item());
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
        end
        req.valid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
